// ===== src/i2cmbp_pkg.sv =====
// shared types and constants for the i2c master bit phase engine
// used by every module of the block, depends on nothing
`default_nettype none

package i2cmbp_pkg;

    localparam int BITS_PER_BYTE = 8;
    localparam int BIT_W         = $clog2(BITS_PER_BYTE);
    localparam int CMD_DEPTH     = 2;
    localparam int CMD_PTR_W     = $clog2(CMD_DEPTH);
    localparam int CMD_CNT_W     = $clog2(CMD_DEPTH + 1);

    localparam logic [BIT_W-1:0] LAST_BIT_BYTE = BIT_W'(BITS_PER_BYTE - 1);
    localparam logic [BIT_W-1:0] LAST_BIT_ACK  = '0;

    // command codes on the mode port
    typedef enum logic [2:0] {
        MODE_START     = 3'd0,
        MODE_STOP      = 3'd1,
        MODE_SEND_BYTE = 3'd2,
        MODE_RECV_BYTE = 3'd3,
        MODE_SEND_ACK  = 3'd4,
        MODE_RECV_ACK  = 3'd5
    } mode_t;

    // phase sequence kinds run by the back end
    typedef enum logic [2:0] {
        KIND_START,
        KIND_STOP,
        KIND_SEND,
        KIND_RECV,
        KIND_RECV_ACK
    } kind_t;

    typedef struct packed {
        kind_t            kind;
        logic [BIT_W-1:0] last_bit;
        logic [7:0]       data;
        logic [7:0]       line;
    } cmd_t;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       sample_point;
        logic [7:0] rx_byte;
        logic       ack_in;
        logic       last_phase;
    } phase_t;

endpackage

`default_nettype wire

// ===== src/i2c_master_bit_phases.sv =====
// i2c master bit phase engine, turns bus requests into scl/sda line phases
//
// input side is a queue: a request (mode, tx_byte, ack_out, line_bits) is
// taken on a clock edge with push high and full low. modes 6 and 7 are
// taken and dropped with no phases.
// result side is a queue: while empty is low the oldest phase is on
// scl_level, sda_level, sample_point, rx_byte, ack_in and last_phase; it
// is taken on an edge with pop high. last_phase marks the final phase of
// a request.
// one phase per cycle while the result side is empty or popped: start
// gives 4, stop 3, send byte 24, receive byte 17, send ack 3 and receive
// ack 3 phases. a taken request goes through the queue and sequencer
// registers before its first phase; consecutive requests have no gap.
// a two-entry request queue lets new requests in while the sequencer runs;
// when pop stays low the sequencer holds its phase and the queue fills,
// then full rises. reset empties both queues and sets the held scl and sda levels high.
// depends on i2cmbp_pkg, i2cmbp_front, i2cmbp_cmd_queue, i2cmbp_back
`default_nettype none

module i2c_master_bit_phases
    import i2cmbp_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    output      logic       full,
    input  wire logic [2:0] mode,
    input  wire logic [7:0] tx_byte,
    input  wire logic       ack_out,
    input  wire logic [7:0] line_bits,
    output      logic       empty,
    input  wire logic       pop,
    output      logic       scl_level,
    output      logic       sda_level,
    output      logic       sample_point,
    output      logic [7:0] rx_byte,
    output      logic       ack_in,
    output      logic       last_phase
);

    logic   cmd_push;
    cmd_t   wr_cmd;
    logic   cmd_pop;
    logic   cmd_valid;
    cmd_t   rd_cmd;
    phase_t phase;

    i2cmbp_front u_front (
        .mode      (mode),
        .tx_byte   (tx_byte),
        .ack_out   (ack_out),
        .line_bits (line_bits),
        .push      (push),
        .full      (full),
        .cmd_push  (cmd_push),
        .cmd       (wr_cmd)
    );

    i2cmbp_cmd_queue u_cmd_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cmd_push),
        .wr_cmd   (wr_cmd),
        .full     (full),
        .rd_en    (cmd_pop),
        .rd_valid (cmd_valid),
        .rd_cmd   (rd_cmd)
    );

    i2cmbp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (rd_cmd),
        .cmd_pop   (cmd_pop),
        .pop       (pop),
        .empty     (empty),
        .phase     (phase)
    );

    assign scl_level    = phase.scl_level;
    assign sda_level    = phase.sda_level;
    assign sample_point = phase.sample_point;
    assign rx_byte      = phase.rx_byte;
    assign ack_in       = phase.ack_in;
    assign last_phase   = phase.last_phase;

endmodule

`default_nettype wire

// ===== src/i2cmbp_front.sv =====
// front end: decodes incoming bus requests into phase sequence commands
// depends on i2cmbp_pkg
`default_nettype none

module i2cmbp_front
    import i2cmbp_pkg::*;
(
    input  wire logic [2:0] mode,
    input  wire logic [7:0] tx_byte,
    input  wire logic       ack_out,
    input  wire logic [7:0] line_bits,
    input  wire logic       push,
    input  wire logic       full,
    output      logic       cmd_push,
    output      cmd_t       cmd
);

    logic known;

    always_comb
    begin
        known         = 1'b1;
        cmd.kind      = KIND_START;
        cmd.last_bit  = LAST_BIT_ACK;
        cmd.data      = tx_byte;
        cmd.line      = line_bits;
        case (mode)
            MODE_START:
            begin
                cmd.kind = KIND_START;
            end
            MODE_STOP:
            begin
                cmd.kind = KIND_STOP;
            end
            MODE_SEND_BYTE:
            begin
                cmd.kind     = KIND_SEND;
                cmd.last_bit = LAST_BIT_BYTE;
            end
            MODE_RECV_BYTE:
            begin
                cmd.kind     = KIND_RECV;
                cmd.last_bit = LAST_BIT_BYTE;
            end
            MODE_SEND_ACK:
            begin
                // one bit send, the ack level rides in the msb
                cmd.kind = KIND_SEND;
                cmd.data = {ack_out, 7'b0};
            end
            MODE_RECV_ACK:
            begin
                cmd.kind = KIND_RECV_ACK;
            end
            default:
            begin
                // unused codes give no phases
                known = 1'b0;
            end
        endcase
    end

    assign cmd_push = push && !full && known;

endmodule

`default_nettype wire

// ===== src/i2cmbp_cmd_queue.sv =====
// short command queue between the front end and the phase sequencer
// depends on i2cmbp_pkg
`default_nettype none

module i2cmbp_cmd_queue
    import i2cmbp_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic wr_en,
    input  wire cmd_t wr_cmd,
    output      logic full,
    input  wire logic rd_en,
    output      logic rd_valid,
    output      cmd_t rd_cmd
);

    cmd_t                 entry_reg [CMD_DEPTH];
    logic [CMD_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CMD_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CMD_CNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == CMD_CNT_W'(CMD_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_cmd   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_en ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = rd_en ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

endmodule

`default_nettype wire

// ===== src/i2cmbp_back.sv =====
// back end: steps through the line phases of one command, one phase per cycle while the result is empty or popped
// holds the scl/sda levels and the result register; depends on i2cmbp_pkg
`default_nettype none

module i2cmbp_back
    import i2cmbp_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   cmd_valid,
    input  wire cmd_t   cmd,
    output      logic   cmd_pop,
    input  wire logic   pop,
    output      logic   empty,
    output      phase_t phase
);

    logic             busy_reg, busy_next;
    kind_t            kind_reg, kind_next;
    logic [1:0]       sub_reg, sub_next;
    logic [BIT_W-1:0] bit_reg, bit_next;
    logic [BIT_W-1:0] last_bit_reg, last_bit_next;
    logic [7:0]       data_reg, data_next;
    logic [7:0]       line_reg, line_next;
    logic             scl_reg, scl_next;
    logic             sda_reg, sda_next;
    logic             out_valid_reg, out_valid_next;
    phase_t           out_reg, out_next;

    phase_t           cur;
    logic [1:0]       step_sub;
    logic [BIT_W-1:0] step_bit;
    logic [7:0]       step_data;
    logic             advance;
    logic             load;

    // phase produced by the current step
    always_comb
    begin
        cur           = '0;
        cur.scl_level = scl_reg;
        cur.sda_level = sda_reg;
        step_sub      = sub_reg + 1'b1;
        step_bit      = bit_reg;
        step_data     = data_reg;
        case (kind_reg)
            KIND_START:
            begin
                case (sub_reg)
                    2'd0: cur.sda_level = 1'b1;
                    2'd1: cur.scl_level = 1'b1;
                    2'd2: cur.sda_level = 1'b0;
                    default:
                    begin
                        cur.scl_level  = 1'b0;
                        cur.last_phase = 1'b1;
                    end
                endcase
            end
            KIND_STOP:
            begin
                case (sub_reg)
                    2'd0: cur.sda_level = 1'b0;
                    2'd1: cur.scl_level = 1'b1;
                    default:
                    begin
                        cur.sda_level  = 1'b1;
                        cur.last_phase = 1'b1;
                    end
                endcase
            end
            KIND_SEND:
            begin
                case (sub_reg)
                    2'd0: cur.sda_level = data_reg[7];
                    2'd1: cur.scl_level = 1'b1;
                    default:
                    begin
                        cur.scl_level  = 1'b0;
                        cur.last_phase = (bit_reg == last_bit_reg);
                        step_sub       = 2'd0;
                        step_bit       = bit_reg + 1'b1;
                        step_data      = {data_reg[6:0], 1'b0};
                    end
                endcase
            end
            KIND_RECV, KIND_RECV_ACK:
            begin
                case (sub_reg)
                    2'd0: cur.sda_level = 1'b1;
                    2'd1:
                    begin
                        cur.scl_level    = 1'b1;
                        cur.sample_point = 1'b1;
                    end
                    default:
                    begin
                        cur.scl_level  = 1'b0;
                        cur.last_phase = (bit_reg == last_bit_reg);
                        // the release phase happens once, later bits restart at scl high
                        step_sub       = 2'd1;
                        step_bit       = bit_reg + 1'b1;
                        if (cur.last_phase)
                        begin
                            if (kind_reg == KIND_RECV)
                            begin
                                cur.rx_byte = line_reg;
                            end
                            else
                            begin
                                cur.ack_in = line_reg[7];
                            end
                        end
                    end
                endcase
            end
            default:
            begin
                cur.last_phase = 1'b1;
            end
        endcase
    end

    assign advance = busy_reg && (!out_valid_reg || pop);
    assign load    = cmd_valid && (!busy_reg || (advance && cur.last_phase));
    assign cmd_pop = load;

    always_comb
    begin
        busy_next      = busy_reg;
        kind_next      = kind_reg;
        sub_next       = sub_reg;
        bit_next       = bit_reg;
        last_bit_next  = last_bit_reg;
        data_next      = data_reg;
        line_next      = line_reg;
        scl_next       = scl_reg;
        sda_next       = sda_reg;
        out_valid_next = out_valid_reg && !pop;
        out_next       = out_reg;
        if (advance)
        begin
            scl_next       = cur.scl_level;
            sda_next       = cur.sda_level;
            out_valid_next = 1'b1;
            out_next       = cur;
            sub_next       = step_sub;
            bit_next       = step_bit;
            data_next      = step_data;
            busy_next      = !cur.last_phase;
        end
        if (load)
        begin
            busy_next     = 1'b1;
            kind_next     = cmd.kind;
            sub_next      = 2'd0;
            bit_next      = '0;
            last_bit_next = cmd.last_bit;
            data_next     = cmd.data;
            line_next     = cmd.line;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            kind_reg      <= KIND_START;
            sub_reg       <= '0;
            bit_reg       <= '0;
            scl_reg       <= 1'b1;
            sda_reg       <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            kind_reg      <= kind_next;
            sub_reg       <= sub_next;
            bit_reg       <= bit_next;
            scl_reg       <= scl_next;
            sda_reg       <= sda_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        last_bit_reg <= last_bit_next;
        data_reg     <= data_next;
        line_reg     <= line_next;
        out_reg      <= out_next;
    end

    assign empty = !out_valid_reg;
    assign phase = out_reg;

endmodule

`default_nettype wire
